FILE: rtl/pcd_pkg.sv
// ----------------------------------------------------------------------------
// pcd_pkg
// Shared types and codes of the permutation cycle decomposer.
// ----------------------------------------------------------------------------
package pcd_pkg;

  // Status codes of a result item
  localparam logic [1:0] ST_ELEM    = 2'd0;
  localparam logic [1:0] ST_OK      = 2'd1;
  localparam logic [1:0] ST_NOTBIJ  = 2'd2;
  localparam logic [1:0] ST_TOOMANY = 2'd3;

  // Error flag bit positions
  localparam int ERR_BIJ  = 0;
  localparam int ERR_MANY = 1;

  // One input item
  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } in_item_t;

  // One result item
  typedef struct packed {
    logic [5:0] element;
    logic       cycle_end;
    logic [1:0] status;
    logic       run_end;
  } out_item_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;        // store one entry
    logic scan_start;  // reset scan index and cycle count
    logic scan_next;   // skip an already visited index
    logic walk_start;  // begin following from the scan index
    logic walk_step;   // one step along the current cycle
    logic summary;     // emit the summary and clear the run
  } pcd_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic err_any;     // run is in error
    logic scan_done;   // scan index reached the entry count
    logic visited;     // scan index already visited
    logic walk_close;  // next image returns to the cycle start
  } pcd_sts_t;

endpackage

FILE: rtl/permutation_cycle_decomposer.sv
// ----------------------------------------------------------------------------
// permutation_cycle_decomposer
// Loads a permutation, checks it is a bijection and emits its nontrivial
// cycles followed by one summary result per run.
// ----------------------------------------------------------------------------
//  channel  ports                       transfer
//  input    start, busy, in_data        start && !busy at a rising edge
//  result   out_valid, out_data         out_valid for one cycle, always taken
//
//  Entries load one per cycle. After the last entry the controller passes
//  through a check state and then, if the check passes, scans each index in
//  turn and walks each cycle element and each fixed point, all through the
//  single read port of the image memory. busy is high from the last entry until the
//  summary is issued. Reset (rst_n, synchronous) empties the run; the image
//  memory needs no clearing. The receiver cannot stall.
module permutation_cycle_decomposer
  import pcd_pkg::*;
#(
  parameter int MAX_ENTRIES = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_data,
  output logic      out_valid,
  output out_item_t out_data
);

  pcd_cmd_t cmd;
  pcd_sts_t sts;

  pcd_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_last (in_data.last),
    .sts     (sts),
    .busy    (busy),
    .cmd     (cmd)
  );

  pcd_dp #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

FILE: rtl/pcd_ctrl.sv
// ----------------------------------------------------------------------------
// pcd_ctrl
// Sequencer: load, bijection check, index scan and cycle walk.
// ----------------------------------------------------------------------------
module pcd_ctrl
  import pcd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  logic     in_last,
  input  pcd_sts_t sts,
  output logic     busy,
  output pcd_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CHECK = 4'b0010,
    S_SCAN  = 4'b0100,
    S_WALK  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  assign busy = (state_r != S_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (in_last) state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.err_any) begin
          cmd.summary = 1'b1;
          state_nxt   = S_IDLE;
        end else begin
          cmd.scan_start = 1'b1;
          state_nxt      = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.scan_done) begin
          cmd.summary = 1'b1;
          state_nxt   = S_IDLE;
        end else if (sts.visited) begin
          cmd.scan_next = 1'b1;
        end else begin
          cmd.walk_start = 1'b1;
          state_nxt      = S_WALK;
        end
      end
      S_WALK: begin
        cmd.walk_step = 1'b1;
        if (sts.walk_close) state_nxt = S_SCAN;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

FILE: rtl/pcd_dp.sv
// ----------------------------------------------------------------------------
// pcd_dp
// Datapath: image memory, seen and visited marks, counters, result register.
// ----------------------------------------------------------------------------
module pcd_dp
  import pcd_pkg::*;
#(
  parameter  int MAX_ENTRIES = 32,
  localparam int IW = $clog2(MAX_ENTRIES),
  localparam int NW = $clog2(MAX_ENTRIES + 1),
  localparam int CW = $clog2(MAX_ENTRIES / 2 + 1)
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_data,
  input  pcd_cmd_t  cmd,
  output pcd_sts_t  sts,
  output logic      out_valid,
  output out_item_t out_data
);

  logic [IW-1:0]          img_mem [MAX_ENTRIES];
  logic [IW-1:0]          rd_r;
  logic [IW-1:0]          rd_addr;
  logic [MAX_ENTRIES-1:0] seen_r, visited_r;
  logic [NW-1:0]          count_r, i_r;
  logic [IW-1:0]          j_r, max_r;
  logic [1:0]             err_r;
  logic [CW-1:0]          cycles_r;
  logic                   out_valid_r;
  out_item_t              out_r;

  logic          full, v_big, bij_err, walk_fixed, walk_close, emit_elem;
  logic [IW-1:0] v_idx, i_idx;

  // Load-side decode
  assign full    = (count_r == NW'(MAX_ENTRIES));
  assign v_big   = (in_data.value >= 8'(MAX_ENTRIES));
  assign v_idx   = in_data.value[IW-1:0];
  assign i_idx   = i_r[IW-1:0];
  // a value at or beyond n but below MAX_ENTRIES shows as the largest value reaching the count
  assign bij_err = err_r[ERR_BIJ] | ({{(NW-IW){1'b0}}, max_r} >= count_r);

  // Walk decode
  assign walk_close = (rd_r == i_idx);
  assign walk_fixed = walk_close && (j_r == i_idx);
  assign emit_elem  = cmd.walk_step && !walk_fixed;

  assign sts.err_any    = err_r[ERR_MANY] | bij_err;
  assign sts.scan_done  = (i_r == count_r);
  assign sts.visited    = visited_r[i_idx];
  assign sts.walk_close = walk_close;

  // Memory read address: scan index, or the image just read while walking
  assign rd_addr = cmd.walk_step ? rd_r : i_idx;

  // Image memory
  always_ff @(posedge clk) begin
    if (cmd.load && !full) img_mem[count_r[IW-1:0]] <= v_big ? '0 : v_idx;
    rd_r <= img_mem[rd_addr];
  end

  // Run state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      err_r       <= '0;
      seen_r      <= '0;
      visited_r   <= '0;
      max_r       <= '0;
      i_r         <= '0;
      j_r         <= '0;
      cycles_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= emit_elem | cmd.summary;
      if (cmd.load) begin
        if (full) begin
          err_r[ERR_MANY] <= 1'b1;
        end else begin
          count_r <= count_r + NW'(1);
          if (v_big) begin
            err_r[ERR_BIJ] <= 1'b1;
          end else begin
            if (seen_r[v_idx]) err_r[ERR_BIJ] <= 1'b1;
            seen_r[v_idx] <= 1'b1;
            if (v_idx > max_r) max_r <= v_idx;
          end
        end
      end
      if (cmd.scan_start) begin
        i_r      <= '0;
        cycles_r <= '0;
      end
      if (cmd.scan_next)  i_r <= i_r + NW'(1);
      if (cmd.walk_start) j_r <= i_idx;
      // follow the mapping one element a cycle
      if (cmd.walk_step) begin
        if (!walk_fixed) visited_r[j_r] <= 1'b1;
        if (walk_close) begin
          i_r <= i_r + NW'(1);
          if (!walk_fixed) cycles_r <= cycles_r + CW'(1);
        end else begin
          j_r <= rd_r;
        end
      end
      // summary ends the run: clear for the next one
      if (cmd.summary) begin
        count_r   <= '0;
        err_r     <= '0;
        seen_r    <= '0;
        visited_r <= '0;
        max_r     <= '0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.summary) begin
      out_r.cycle_end <= 1'b0;
      out_r.run_end   <= 1'b1;
      if (err_r[ERR_MANY]) begin
        out_r.element <= '0;
        out_r.status  <= ST_TOOMANY;
      end else if (bij_err) begin
        out_r.element <= '0;
        out_r.status  <= ST_NOTBIJ;
      end else begin
        out_r.element <= 6'(cycles_r);
        out_r.status  <= ST_OK;
      end
    end else if (emit_elem) begin
      out_r.element   <= 6'(j_r);
      out_r.cycle_end <= walk_close;
      out_r.status    <= ST_ELEM;
      out_r.run_end   <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Checks
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= NW'(MAX_ENTRIES))
    else $error("entry count beyond capacity");

  a_clear_after_summary: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.summary |=> (count_r == '0) && (err_r == '0))
    else $error("run state not cleared after summary");

  a_walk_unvisited: assert property (@(posedge clk) disable iff (!rst_n)
    emit_elem |-> !visited_r[j_r])
    else $error("cycle walk revisited an element");

  a_elem_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_r.run_end |-> ({1'b0, out_r.element} < 7'(count_r)))
    else $error("emitted element beyond entry count");

endmodule
